// ===== hw/rtl/lrupr_pkg.sv =====
// shared constants and types for the lru page replacement block
package lrupr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int CFG_W   = 4;
    localparam int SLOT_W  = 3;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd4;
    localparam logic [FAULT_W-1:0] FAULT_MAX    = 32'hFFFF_FFFF;

    // one-cycle operations on the valid and rank lanes
    typedef struct packed {
        logic clear_all;
        logic touch;
        logic load;
        logic drop_start;
        logic comp_step;
        logic drop_end;
    } t_rank_op;

endpackage

// ===== hw/rtl/lrupr_ifs.sv =====
// channel interfaces: page reference, frame count write, result
interface lrupr_ref_if #(
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;
    logic                 first_of_string;

    modport source (output valid, output page, output first_of_string, input ready);
    modport sink   (input valid, input page, input first_of_string, output ready);
endinterface

interface lrupr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lrupr_pkg::CFG_W-1:0]   wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

interface lrupr_res_if #(
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic                            evicted_valid;
    logic [PAGE_BITS-1:0]            evicted_page;
    logic [lrupr_pkg::SLOT_W-1:0]    slot;
    logic [lrupr_pkg::FAULT_W-1:0]   fault_total;

    modport source (output valid, output hit, output evicted_valid, output evicted_page,
                    output slot, output fault_total, input ready);
    modport sink   (input valid, input hit, input evicted_valid, input evicted_page,
                    input slot, input fault_total, output ready);
endinterface

// ===== hw/rtl/lrupr_page_mem.sv =====
// page number store, one write and one registered read per cycle
module lrupr_page_mem #(
    parameter int DEPTH = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int WIDTH = lrupr_pkg::PAGE_BITS_DEF,
    parameter int AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== hw/rtl/lrupr_rank_file.sv =====
// per-frame valid bits and recency ranks with parallel touch and compaction lanes
module lrupr_rank_file #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int IDX_W      = 3,
    parameter int CNT_W      = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrupr_pkg::t_rank_op i_op,
    input  logic [IDX_W-1:0]    i_slot,
    input  logic [CNT_W-1:0]    i_lim,
    input  logic [IDX_W-1:0]    i_comp_rank,
    input  logic [IDX_W-1:0]    i_rd_idx,
    output logic                o_rd_valid,
    output logic [IDX_W-1:0]    o_rd_rank
);

    logic             r_valid [MAX_FRAMES];
    logic             n_valid [MAX_FRAMES];
    logic [IDX_W-1:0] r_rank  [MAX_FRAMES];
    logic [IDX_W-1:0] n_rank  [MAX_FRAMES];
    logic             r_drop  [MAX_FRAMES];
    logic             n_drop  [MAX_FRAMES];
    logic [IDX_W-1:0] old_rank;
    logic             comp_hit;

    always_comb begin
        n_valid  = r_valid;
        n_rank   = r_rank;
        n_drop   = r_drop;
        old_rank = r_rank[i_slot];
        comp_hit = 1'b0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (r_drop[k] && r_rank[k] == i_comp_rank) begin
                comp_hit = 1'b1;
            end
        end

        if (i_op.clear_all) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                n_valid[k] = 1'b0;
                n_rank[k]  = '0;
                n_drop[k]  = 1'b0;
            end
        end else begin
            if (i_op.touch) begin
                for (int k = 0; k < MAX_FRAMES; k++) begin
                    if (k == int'(i_slot)) begin
                        n_rank[k] = '0;
                        if (i_op.load) begin
                            n_valid[k] = 1'b1;
                        end
                    end else if (r_valid[k] && (i_op.load || r_rank[k] < old_rank)) begin
                        n_rank[k] = r_rank[k] + 1'b1;
                    end
                end
            end
            if (i_op.drop_start) begin
                for (int k = 0; k < MAX_FRAMES; k++) begin
                    n_drop[k] = r_valid[k] && (k >= int'(i_lim));
                end
            end
            // removed ranks go highest first, so kept ranks close the gaps in order
            if (i_op.comp_step) begin
                for (int k = 0; k < MAX_FRAMES; k++) begin
                    if (r_valid[k] && !r_drop[k] && comp_hit && r_rank[k] > i_comp_rank) begin
                        n_rank[k] = r_rank[k] - 1'b1;
                    end
                end
            end
            if (i_op.drop_end) begin
                for (int k = 0; k < MAX_FRAMES; k++) begin
                    if (r_drop[k]) begin
                        n_valid[k] = 1'b0;
                        n_rank[k]  = '0;
                        n_drop[k]  = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                r_valid[k] <= 1'b0;
                r_rank[k]  <= '0;
                r_drop[k]  <= 1'b0;
            end
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_drop  <= n_drop;
        end
    end

    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_rank  = r_rank[i_rd_idx];

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// top level: lru page replacement over a small set of frame slots
//
// channels: i_ref takes one page reference per transaction (page, first_of_string),
// o_res returns one result per reference (hit, evicted_valid, evicted_page, slot,
// fault_total), i_cfg writes the frames-in-use register (0 acts as 1, values above
// MAX_FRAMES act as MAX_FRAMES)
// a reference is scanned one frame per cycle through a single page comparator and
// rank compare, fed by the registered read of the page store; the frame limit sets
// the scan length; after the scan the ranks and the page store are updated and the
// result is written to the output register, and i_ref is not ready meanwhile
// a frame-count write keeps the block busy in the drop and compact states, which
// invalidate the dropped slots and compact the ranks, one rank value per cycle, with
// i_ref held off
// after reset all frames are empty, the fault count is zero and the limit is four
// the result sits in an output register; while the receiver stalls the block
// still takes the next reference and only waits once a second result is done
module lru_page_replacement #(
    parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lrupr_ref_if.sink     i_ref,
    lrupr_cfg_if.sink     i_cfg,
    lrupr_res_if.source   o_res
);

    localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int SLOT_W  = lrupr_pkg::SLOT_W;
    localparam int FAULT_W = lrupr_pkg::FAULT_W;
    localparam int CFG_W   = lrupr_pkg::CFG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD,
        ST_WAIT,
        ST_DROP,
        ST_COMPACT
    } t_state;

    t_state               r_state,       n_state;
    logic [CFG_W-1:0]     r_cfg,         n_cfg;
    logic [PAGE_BITS-1:0] r_page,        n_page;
    logic [CNT_W-1:0]     r_idx,         n_idx;
    logic                 r_cmp_vld,     n_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx,     n_cmp_idx;
    logic                 r_found,       n_found;
    logic [IDX_W-1:0]     r_hit_slot,    n_hit_slot;
    logic                 r_free,        n_free;
    logic [IDX_W-1:0]     r_free_slot,   n_free_slot;
    logic [IDX_W-1:0]     r_old_slot,    n_old_slot;
    logic [IDX_W-1:0]     r_old_rank,    n_old_rank;
    logic [PAGE_BITS-1:0] r_ev_page,     n_ev_page;
    logic [FAULT_W-1:0]   r_fault,       n_fault;
    logic [IDX_W-1:0]     r_crank,       n_crank;
    logic                 r_out_vld,     n_out_vld;
    logic                 r_out_hit,     n_out_hit;
    logic                 r_out_ev_vld,  n_out_ev_vld;
    logic [PAGE_BITS-1:0] r_out_ev_page, n_out_ev_page;
    logic [SLOT_W-1:0]    r_out_slot,    n_out_slot;
    logic [FAULT_W-1:0]   r_out_fault,   n_out_fault;

    logic [CNT_W-1:0]     lim;
    logic                 cfg_fire;
    logic                 ref_fire;
    logic                 out_take;
    logic                 out_free;
    logic                 res_ev;
    logic [IDX_W-1:0]     res_slot;

    lrupr_pkg::t_rank_op  rk_op;
    logic [IDX_W-1:0]     rk_slot;
    logic                 rd_valid;
    logic [IDX_W-1:0]     rd_rank;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [IDX_W-1:0]     mem_raddr;
    logic [PAGE_BITS-1:0] mem_q;

    // effective frame limit, clamped to 1..MAX_FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            lim = CNT_W'(1);
        end else if (int'(r_cfg) > MAX_FRAMES) begin
            lim = CNT_W'(MAX_FRAMES);
        end else begin
            lim = CNT_W'(r_cfg);
        end
    end

    assign i_cfg.ready = (r_state == ST_IDLE);
    assign i_ref.ready = (r_state == ST_IDLE) && !i_cfg.valid;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign ref_fire    = i_ref.valid && i_ref.ready;
    assign out_take    = r_out_vld && o_res.ready;
    assign out_free    = !r_out_vld || out_take;

    // result of the finished scan
    assign res_ev   = !r_found && !r_free;
    assign res_slot = r_found ? r_hit_slot : (r_free ? r_free_slot : r_old_slot);

    always_comb begin
        n_state       = r_state;
        n_cfg         = r_cfg;
        n_page        = r_page;
        n_idx         = r_idx;
        n_cmp_vld     = r_cmp_vld;
        n_cmp_idx     = r_cmp_idx;
        n_found       = r_found;
        n_hit_slot    = r_hit_slot;
        n_free        = r_free;
        n_free_slot   = r_free_slot;
        n_old_slot    = r_old_slot;
        n_old_rank    = r_old_rank;
        n_ev_page     = r_ev_page;
        n_fault       = r_fault;
        n_crank       = r_crank;
        n_out_vld     = out_take ? 1'b0 : r_out_vld;
        n_out_hit     = r_out_hit;
        n_out_ev_vld  = r_out_ev_vld;
        n_out_ev_page = r_out_ev_page;
        n_out_slot    = r_out_slot;
        n_out_fault   = r_out_fault;
        rk_op         = '0;
        rk_slot       = res_slot;
        mem_we        = 1'b0;
        mem_waddr     = res_slot;
        mem_raddr     = r_idx[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (cfg_fire) begin
                    n_cfg   = i_cfg.wdata;
                    n_state = ST_DROP;
                end else if (ref_fire) begin
                    n_page     = i_ref.page;
                    n_idx      = '0;
                    n_cmp_vld  = 1'b0;
                    n_found    = 1'b0;
                    n_free     = 1'b0;
                    n_old_rank = '0;
                    n_old_slot = '0;
                    if (i_ref.first_of_string) begin
                        rk_op.clear_all = 1'b1;
                        n_fault         = '0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue one frame read per cycle
                if (r_idx < lim) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                    n_state   = ST_UPD;
                end
                // compare the frame read in the previous cycle
                if (r_cmp_vld) begin
                    if (!r_found && rd_valid && mem_q == r_page) begin
                        n_found    = 1'b1;
                        n_hit_slot = r_cmp_idx;
                    end
                    if (!r_free && !rd_valid) begin
                        n_free      = 1'b1;
                        n_free_slot = r_cmp_idx;
                    end
                    if (rd_valid && (r_cmp_idx == '0 || rd_rank > r_old_rank)) begin
                        n_old_rank = rd_rank;
                        n_old_slot = r_cmp_idx;
                        n_ev_page  = mem_q;
                    end
                end
            end
            ST_UPD: begin
                rk_op.touch = 1'b1;
                if (!r_found) begin
                    rk_op.load = r_free;
                    mem_we     = 1'b1;
                    if (r_fault != lrupr_pkg::FAULT_MAX) begin
                        n_fault = r_fault + 1'b1;
                    end
                end
                if (out_free) begin
                    n_out_vld     = 1'b1;
                    n_out_hit     = r_found;
                    n_out_ev_vld  = res_ev;
                    n_out_ev_page = res_ev ? r_ev_page : '0;
                    n_out_slot    = SLOT_W'(res_slot);
                    n_out_fault   = n_fault;
                    n_state       = ST_IDLE;
                end else begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (out_free) begin
                    n_out_vld     = 1'b1;
                    n_out_hit     = r_found;
                    n_out_ev_vld  = res_ev;
                    n_out_ev_page = res_ev ? r_ev_page : '0;
                    n_out_slot    = SLOT_W'(res_slot);
                    n_out_fault   = r_fault;
                    n_state       = ST_IDLE;
                end
            end
            ST_DROP: begin
                rk_op.drop_start = 1'b1;
                n_crank          = IDX_W'(MAX_FRAMES - 1);
                n_state          = ST_COMPACT;
            end
            ST_COMPACT: begin
                rk_op.comp_step = 1'b1;
                if (r_crank == '0) begin
                    rk_op.drop_end = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    n_crank = r_crank - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= lrupr_pkg::FRAMES_RESET;
            r_fault   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cfg     <= n_cfg;
            r_fault   <= n_fault;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
        r_page        <= n_page;
        r_idx         <= n_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_found       <= n_found;
        r_hit_slot    <= n_hit_slot;
        r_free        <= n_free;
        r_free_slot   <= n_free_slot;
        r_old_slot    <= n_old_slot;
        r_old_rank    <= n_old_rank;
        r_ev_page     <= n_ev_page;
        r_crank       <= n_crank;
        r_out_hit     <= n_out_hit;
        r_out_ev_vld  <= n_out_ev_vld;
        r_out_ev_page <= n_out_ev_page;
        r_out_slot    <= n_out_slot;
        r_out_fault   <= n_out_fault;
    end

    lrupr_page_mem #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (PAGE_BITS),
        .AW    (IDX_W)
    ) u_page_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_page),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    lrupr_rank_file #(
        .MAX_FRAMES (MAX_FRAMES),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_rank_file (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (rk_op),
        .i_slot      (rk_slot),
        .i_lim       (lim),
        .i_comp_rank (r_crank),
        .i_rd_idx    (r_cmp_idx),
        .o_rd_valid  (rd_valid),
        .o_rd_rank   (rd_rank)
    );

    assign o_res.valid         = r_out_vld;
    assign o_res.hit           = r_out_hit;
    assign o_res.evicted_valid = r_out_ev_vld;
    assign o_res.evicted_page  = r_out_ev_page;
    assign o_res.slot          = r_out_slot;
    assign o_res.fault_total   = r_out_fault;

endmodule
